>>> design/mi3_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the 3x3 matrix inverse block.
// Used by the front, queue, back and top-level modules.
package mi3_pkg;
  localparam int ELEMENT_BITS_DEFAULT = 8;
  localparam int FRAC_BITS = 16;
  localparam int DET_FIELD_BITS = 25;
  localparam int INV_BITS = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_DATA_BITS = ((9 * INV_BITS + DET_FIELD_BITS + 7) / 8) * 8;
endpackage

>>> design/mi3_front.sv
`timescale 1ns / 1ps
// Front end: accepts matrices and forms cofactors and determinant in three stages.
// Depends on mi3_pkg.
module mi3_front import mi3_pkg::*; #(
  parameter int ELEMENT_BITS = ELEMENT_BITS_DEFAULT,
  parameter int IN_W = ((9 * ELEMENT_BITS + 7) / 8) * 8,
  parameter int CW = 2 * ELEMENT_BITS + 1,
  parameter int DW = 3 * ELEMENT_BITS + 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [IN_W-1:0]   in_data,
  output logic              push,
  input  logic              full,
  output logic [9*CW+DW-1:0] push_data
);
  localparam int E = ELEMENT_BITS;
  localparam int PW = 2 * E;

  logic signed [E-1:0] m [9];
  logic signed [PW-1:0] pa_next [9];
  logic signed [PW-1:0] pb_next [9];
  logic signed [PW-1:0] pa [9];
  logic signed [PW-1:0] pb [9];
  logic signed [CW-1:0] cof_next [9];
  logic signed [CW-1:0] cof [9];
  logic signed [CW-1:0] cof3 [9];
  logic signed [E-1:0] m0_s1 [3];
  logic signed [E-1:0] m0_s2 [3];
  logic signed [DW-1:0] dp [3];
  logic signed [DW-1:0] det_next;
  logic signed [DW-1:0] det;
  logic v1, v2, v3;
  logic en;

  assign en = !v3 || !full;
  assign in_ready = en;
  assign push = v3 && !full;

  genvar g;
  generate
    for (g = 0; g < 9; g++) begin : g_cof
      localparam int R = g / 3;
      localparam int C = g % 3;
      localparam int RA = (R == 0) ? 1 : 0;
      localparam int RB = (R == 2) ? 1 : 2;
      localparam int CA = (C == 0) ? 1 : 0;
      localparam int CB = (C == 2) ? 1 : 2;
      logic signed [CW-1:0] minor;
      assign m[g] = in_data[g*E +: E];
      assign pa_next[g] = m[RA*3+CA] * m[RB*3+CB];
      assign pb_next[g] = m[RA*3+CB] * m[RB*3+CA];
      assign minor = CW'(pa[g]) - CW'(pb[g]);
      assign cof_next[g] = (((R + C) % 2) == 1) ? -minor : minor;
      assign push_data[g*CW +: CW] = cof3[g];
    end
    for (g = 0; g < 3; g++) begin : g_det
      assign dp[g] = m0_s2[g] * cof[g];
    end
  endgenerate

  assign det_next = dp[0] + dp[1] + dp[2];
  assign push_data[9*CW +: DW] = det;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa <= pa_next;
      pb <= pb_next;
      cof <= cof_next;
      cof3 <= cof;
      det <= det_next;
      for (int i = 0; i < 3; i++) begin
        m0_s1[i] <= m[i];
        m0_s2[i] <= m0_s1[i];
      end
    end
  end
endmodule

>>> design/mi3_queue.sv
`timescale 1ns / 1ps
// Short first-in first-out queue between the front and back ends.
// Depends on mi3_pkg.
module mi3_queue import mi3_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] pop_data
);
  localparam int AW = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] mem [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0] count;

  assign full = (count == (AW+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

>>> design/mi3_back.sv
`timescale 1ns / 1ps
// Back end: nine pipelined restoring dividers, one quotient bit per stage,
// then sign, saturation and the output register. Depends on mi3_pkg.
module mi3_back import mi3_pkg::*; #(
  parameter int ELEMENT_BITS = ELEMENT_BITS_DEFAULT,
  parameter int CW = 2 * ELEMENT_BITS + 1,
  parameter int DW = 3 * ELEMENT_BITS + 3
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_empty,
  output logic                     q_pop,
  input  logic [9*CW+DW-1:0]       q_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [OUT_DATA_BITS-1:0] out_data,
  output logic                     out_singular
);
  localparam int NB = CW + FRAC_BITS;
  localparam int XW = (NB > INV_BITS) ? NB : INV_BITS + 1;

  logic en;
  logic v [NB+1];
  logic [DW-1:0] den [NB+1];
  logic [DW-1:0] rem [NB+1][9];
  logic [NB-1:0] nq [NB+1][9];
  logic neg [NB+1][9];
  logic zero [NB+1];
  logic [DET_FIELD_BITS-1:0] detf [NB+1];
  logic signed [DW-1:0] det_in;
  logic [INV_BITS-1:0] res_next [9];
  logic [OUT_DATA_BITS-1:0] out_next;

  assign en = !out_valid || out_ready;
  assign q_pop = en && !q_empty;
  assign det_in = q_data[9*CW +: DW];

  genvar g, s;
  generate
    for (g = 0; g < 9; g++) begin : g_lane
      localparam int SRC = (g % 3) * 3 + (g / 3);
      logic signed [CW-1:0] c_in;
      logic [CW-1:0] mag;
      logic [XW-1:0] qx;
      assign c_in = q_data[SRC*CW +: CW];
      assign mag = c_in[CW-1] ? CW'(-c_in) : CW'(c_in);
      always_ff @(posedge clk) begin
        if (en) begin
          rem[0][g] <= '0;
          nq[0][g] <= {mag, {FRAC_BITS{1'b0}}};
          neg[0][g] <= c_in[CW-1] ^ det_in[DW-1];
        end
      end
      for (s = 0; s < NB; s++) begin : g_stage
        logic [DW:0] t;
        logic ge;
        assign t = {rem[s][g], nq[s][g][NB-1]};
        assign ge = (t >= {1'b0, den[s]});
        always_ff @(posedge clk) begin
          if (en) begin
            rem[s+1][g] <= ge ? DW'(t - {1'b0, den[s]}) : t[DW-1:0];
            nq[s+1][g] <= {nq[s][g][NB-2:0], ge};
            neg[s+1][g] <= neg[s][g];
          end
        end
      end
      assign qx = XW'(nq[NB][g]);
      always_comb begin
        if (zero[NB]) begin
          res_next[g] = '0;
        end else if (!neg[NB][g] && qx > XW'(32'h7FFF_FFFF)) begin
          res_next[g] = 32'h7FFF_FFFF;
        end else if (neg[NB][g] && qx > XW'(33'h0_8000_0000)) begin
          res_next[g] = 32'h8000_0000;
        end else if (neg[NB][g]) begin
          res_next[g] = -qx[INV_BITS-1:0];
        end else begin
          res_next[g] = qx[INV_BITS-1:0];
        end
      end
    end
    for (s = 0; s < NB; s++) begin : g_ctl
      always_ff @(posedge clk) begin
        if (en) begin
          den[s+1] <= den[s];
          zero[s+1] <= zero[s];
          detf[s+1] <= detf[s];
        end
      end
      always_ff @(posedge clk) begin
        if (rst) begin
          v[s+1] <= 1'b0;
        end else if (en) begin
          v[s+1] <= v[s];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      den[0] <= det_in[DW-1] ? DW'(-det_in) : DW'(det_in);
      zero[0] <= (det_in == '0);
      detf[0] <= DET_FIELD_BITS'(det_in);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v[0] <= !q_empty;
      out_valid <= v[NB];
    end
  end

  always_comb begin
    out_next = '0;
    for (int i = 0; i < 9; i++) begin
      out_next[i*INV_BITS +: INV_BITS] = res_next[i];
    end
    out_next[9*INV_BITS +: DET_FIELD_BITS] = detf[NB];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= out_next;
      out_singular <= zero[NB];
    end
  end
endmodule

>>> design/matrix_inverse_3x3.sv
`timescale 1ns / 1ps
// Top level of the 3x3 matrix inverse by adjugate and determinant.
// Depends on mi3_pkg, mi3_front, mi3_queue and mi3_back.
//
// Channel  Direction  Contents
// s_*      in         one 3x3 matrix of signed elements per item
// m_*      out        nine Q16.16 inverse entries, determinant, singular flag
//
// One item is accepted per cycle while the front is not stalled; a result passes
// through the three front stages, the queue and one back stage per quotient bit.
// Reset clears only the valid bits, the queue pointers and the queue count. The front and
// back stall independently; the four-entry queue absorbs the difference.
module matrix_inverse_3x3 import mi3_pkg::*; #(
  parameter int ELEMENT_BITS = ELEMENT_BITS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22 from bit 0 up, zero padded.
  input  logic [((9*ELEMENT_BITS+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // inv00 .. inv22 (32 bits each), determinant (25 bits) from bit 0 up, zero padded.
  output logic [OUT_DATA_BITS-1:0] m_tdata,
  // singular.
  output logic m_tuser
);
  localparam int CW = 2 * ELEMENT_BITS + 1;
  localparam int DW = 3 * ELEMENT_BITS + 3;
  localparam int QW = 9 * CW + DW;

  logic push, full, pop, empty;
  logic [QW-1:0] push_data;
  logic [QW-1:0] pop_data;

  mi3_front #(.ELEMENT_BITS(ELEMENT_BITS)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata),
    .push(push), .full(full), .push_data(push_data)
  );

  mi3_queue #(.WIDTH(QW)) u_queue (
    .clk(clk), .rst(rst),
    .push(push), .push_data(push_data), .full(full),
    .pop(pop), .empty(empty), .pop_data(pop_data)
  );

  mi3_back #(.ELEMENT_BITS(ELEMENT_BITS)) u_back (
    .clk(clk), .rst(rst),
    .q_empty(empty), .q_pop(pop), .q_data(pop_data),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .out_data(m_tdata), .out_singular(m_tuser)
  );
endmodule
